// ----- design/ibcc_pkg.sv -----
// Shared constants, types and command/status structs for the brightness/colorfulness classifier.
package ibcc_pkg;

	localparam int MAX_PIXELS_LOG2 = 22;
	localparam int FRAC_BITS       = 4;

	localparam int CNT_W   = MAX_PIXELS_LOG2 + 1;
	localparam int GSUM_W  = 31;
	localparam int RGSUM_W = 31;
	localparam int RGSQ_W  = 39;
	localparam int YBSUM_W = 32;
	localparam int YBSQ_W  = 41;

	localparam int PROD_W  = 64;
	localparam int MULB_W  = 32;
	localparam int MULC_W  = 5;
	localparam int RAD_W   = 80;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int SQC_W   = 6;
	localparam int DVD_W   = 49;
	localparam int DVS_W   = 36;
	localparam int DVC_W   = 6;

	localparam int BM_W    = 12;
	localparam int CV_W    = 13;
	localparam int CLS_W   = 2;
	localparam int BTHR_W  = 8;
	localparam int CTHR_W  = 9;
	localparam int CFGD_W  = 9;

	localparam logic [BTHR_W-1:0] BTHR_RESET = 8'd60;
	localparam logic [CTHR_W-1:0] CTHR_RESET = 9'd30;

	localparam logic CFG_BTHR = 1'b0;
	localparam logic CFG_CTHR = 1'b1;

	localparam logic [CLS_W-1:0] CLS_OTHER    = 2'd0;
	localparam logic [CLS_W-1:0] CLS_BRIGHT   = 2'd1;
	localparam logic [CLS_W-1:0] CLS_COLORFUL = 2'd2;

	localparam logic [1:0] MUL_N_RGSQ  = 2'd0;
	localparam logic [1:0] MUL_RG_RG   = 2'd1;
	localparam logic [1:0] MUL_N_YBSQ  = 2'd2;
	localparam logic [1:0] MUL_YB_YB   = 2'd3;

	typedef struct packed {
		logic       acc_en;
		logic       clear;
		logic       mul_start;
		logic [1:0] mul_sel;
		logic       sqrt_start;
		logic       sqrt_sel;
		logic       div_start;
		logic       div_sel;
		logic       out_load;
	} ibcc_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic sqrt_done;
		logic div_done;
		logic out_free;
	} ibcc_stat_t;

endpackage

// ----- design/ibcc_ctrl.sv -----
// Controller state machine: pixel accumulation and the end-of-frame arithmetic sequence.
module ibcc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                last_pixel,
	input  ibcc_pkg::ibcc_stat_t stat,
	output ibcc_pkg::ibcc_cmd_t  cmd
);
	import ibcc_pkg::*;

	localparam logic [2:0] ST_ACC     = 3'd0;
	localparam logic [2:0] ST_MUL_GO  = 3'd1;
	localparam logic [2:0] ST_MUL_WT  = 3'd2;
	localparam logic [2:0] ST_SQ_GO   = 3'd3;
	localparam logic [2:0] ST_SQ_WT   = 3'd4;
	localparam logic [2:0] ST_DV_GO   = 3'd5;
	localparam logic [2:0] ST_DV_WT   = 3'd6;
	localparam logic [2:0] ST_LOAD    = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] sel_q, sel_d;

	assign in_ready = (state_q == ST_ACC);

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.mul_sel  = sel_q;
		cmd.sqrt_sel = sel_q[0];
		cmd.div_sel  = sel_q[0];
		case (state_q)
			ST_ACC: begin
				if (in_valid) begin
					cmd.acc_en = 1'b1;
					if (last_pixel) begin
						state_d = ST_MUL_GO;
						sel_d   = 2'd0;
					end
				end
			end
			ST_MUL_GO: begin
				cmd.mul_start = 1'b1;
				state_d = ST_MUL_WT;
			end
			ST_MUL_WT: begin
				if (stat.mul_done) begin
					if (sel_q == MUL_YB_YB) begin
						sel_d   = 2'd0;
						state_d = ST_SQ_GO;
					end else begin
						sel_d   = sel_q + 2'd1;
						state_d = ST_MUL_GO;
					end
				end
			end
			ST_SQ_GO: begin
				cmd.sqrt_start = 1'b1;
				state_d = ST_SQ_WT;
			end
			ST_SQ_WT: begin
				if (stat.sqrt_done) begin
					if (sel_q[0]) begin
						sel_d   = 2'd0;
						state_d = ST_DV_GO;
					end else begin
						sel_d   = 2'd1;
						state_d = ST_SQ_GO;
					end
				end
			end
			ST_DV_GO: begin
				cmd.div_start = 1'b1;
				state_d = ST_DV_WT;
			end
			ST_DV_WT: begin
				if (stat.div_done) begin
					if (sel_q[0]) begin
						sel_d   = 2'd0;
						state_d = ST_LOAD;
					end else begin
						sel_d   = 2'd1;
						state_d = ST_DV_GO;
					end
				end
			end
			ST_LOAD: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			sel_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

endmodule

// ----- design/ibcc_dp.sv -----
// Datapath: accumulators, serial multiplier, square root and divider, and the result register.
module ibcc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        red,
	input  logic [7:0]                        green,
	input  logic [7:0]                        blue,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [ibcc_pkg::CFGD_W-1:0]       cfg_data,
	input  ibcc_pkg::ibcc_cmd_t               cmd,
	output ibcc_pkg::ibcc_stat_t              stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ibcc_pkg::BM_W-1:0]         brightness_mean,
	output logic [ibcc_pkg::CV_W-1:0]         colorfulness_value,
	output logic [ibcc_pkg::CLS_W-1:0]        frame_class
);
	import ibcc_pkg::*;

	// Threshold registers.
	logic [BTHR_W-1:0] bthr_q;
	logic [CTHR_W-1:0] cthr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bthr_q <= BTHR_RESET;
			cthr_q <= CTHR_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BTHR) begin
				bthr_q <= cfg_data[BTHR_W-1:0];
			end else begin
				cthr_q <= cfg_data[CTHR_W-1:0];
			end
		end
	end

	// Per-pixel terms.
	logic [21:0] gray_full;
	logic [7:0]  gray;
	logic [7:0]  rg;
	logic [8:0]  sy, b2, yb;
	logic [15:0] rg_sq;
	logic [17:0] yb_sq;

	always_comb begin
		gray_full = 22'(red) * 22'd4899 + 22'(green) * 22'd9617 + 22'(blue) * 22'd1868
			+ 22'd8192;
		gray  = gray_full[21:14];
		rg    = (red > green) ? red - green : green - red;
		sy    = {1'b0, red} + {1'b0, green};
		b2    = {blue, 1'b0};
		yb    = (sy > b2) ? sy - b2 : b2 - sy;
		rg_sq = rg * rg;
		yb_sq = yb * yb;
	end

	logic [CNT_W-1:0]   cnt_q;
	logic [GSUM_W-1:0]  gsum_q;
	logic [RGSUM_W-1:0] rgsum_q;
	logic [RGSQ_W-1:0]  rgsq_q;
	logic [YBSUM_W-1:0] ybsum_q;
	logic [YBSQ_W-1:0]  ybsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			gsum_q  <= '0;
			rgsum_q <= '0;
			rgsq_q  <= '0;
			ybsum_q <= '0;
			ybsq_q  <= '0;
		end else if (cmd.clear) begin
			cnt_q   <= '0;
			gsum_q  <= '0;
			rgsum_q <= '0;
			rgsq_q  <= '0;
			ybsum_q <= '0;
			ybsq_q  <= '0;
		end else if (cmd.acc_en && !cnt_q[CNT_W-1]) begin
			// Once the count reaches its ceiling, further pixels are dropped.
			cnt_q   <= cnt_q + 1'b1;
			gsum_q  <= gsum_q + GSUM_W'(gray);
			rgsum_q <= rgsum_q + RGSUM_W'(rg);
			rgsq_q  <= rgsq_q + RGSQ_W'(rg_sq);
			ybsum_q <= ybsum_q + YBSUM_W'(yb);
			ybsq_q  <= ybsq_q + YBSQ_W'(yb_sq);
		end
	end

	// Shift-and-add multiplier, one multiplier bit per cycle.
	logic [PROD_W-1:0] mul_a_q, mul_p_q, mul_p_nxt;
	logic [MULB_W-1:0] mul_b_q;
	logic [MULC_W-1:0] mul_c_q;
	logic              mul_busy_q;
	logic [PROD_W-1:0] p_q [4];
	logic [PROD_W-1:0] mul_a_init;
	logic [MULB_W-1:0] mul_b_init;

	always_comb begin
		case (cmd.mul_sel)
			MUL_N_RGSQ: begin
				mul_a_init = PROD_W'(rgsq_q);
				mul_b_init = MULB_W'(cnt_q);
			end
			MUL_RG_RG: begin
				mul_a_init = PROD_W'(rgsum_q);
				mul_b_init = MULB_W'(rgsum_q);
			end
			MUL_N_YBSQ: begin
				mul_a_init = PROD_W'(ybsq_q);
				mul_b_init = MULB_W'(cnt_q);
			end
			default: begin
				mul_a_init = PROD_W'(ybsum_q);
				mul_b_init = ybsum_q;
			end
		endcase
		mul_p_nxt = mul_p_q + (mul_b_q[0] ? mul_a_q : '0);
	end

	assign stat.mul_done = mul_busy_q && (mul_c_q == MULC_W'(MULB_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_c_q    <= '0;
		end else if (cmd.mul_start) begin
			mul_busy_q <= 1'b1;
			mul_c_q    <= '0;
		end else if (mul_busy_q) begin
			mul_c_q <= mul_c_q + 1'b1;
			if (stat.mul_done) begin
				mul_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_a_q <= mul_a_init;
			mul_b_q <= mul_b_init;
			mul_p_q <= '0;
		end else if (mul_busy_q) begin
			mul_a_q <= {mul_a_q[PROD_W-2:0], 1'b0};
			mul_b_q <= {1'b0, mul_b_q[MULB_W-1:1]};
			mul_p_q <= mul_p_nxt;
			if (stat.mul_done) begin
				p_q[cmd.mul_sel] <= mul_p_nxt;
			end
		end
	end

	// Radicands: scaled variance sum and scaled squared-mean sum.
	logic [PROD_W-1:0] d1, d2, x1, x2;
	logic [RAD_W-1:0]  rad_init;

	always_comb begin
		d1 = (p_q[MUL_N_RGSQ] >= p_q[MUL_RG_RG]) ? p_q[MUL_N_RGSQ] - p_q[MUL_RG_RG] : '0;
		d2 = (p_q[MUL_N_YBSQ] >= p_q[MUL_YB_YB]) ? p_q[MUL_N_YBSQ] - p_q[MUL_YB_YB] : '0;
		x1 = {d1[PROD_W-3:0], 2'b00} + d2;
		x2 = {p_q[MUL_RG_RG][PROD_W-3:0], 2'b00} + p_q[MUL_YB_YB];
		rad_init = {(cmd.sqrt_sel ? x2 : x1), 16'h0000};
	end

	// Digit-by-digit square root, two radicand bits per cycle.
	logic [RAD_W-1:0]  sq_x_q;
	logic [ROOT_W+1:0] sq_r_q, sq_rsh, sq_trial, sq_r_nxt;
	logic [ROOT_W-1:0] sq_root_q, sq_root_nxt, s1_q, s2_q;
	logic [SQC_W-1:0]  sq_c_q;
	logic              sq_busy_q;

	always_comb begin
		sq_rsh   = {sq_r_q[ROOT_W-1:0], sq_x_q[RAD_W-1:RAD_W-2]};
		sq_trial = {sq_root_q, 2'b01};
		if (sq_rsh >= sq_trial) begin
			sq_r_nxt    = sq_rsh - sq_trial;
			sq_root_nxt = {sq_root_q[ROOT_W-2:0], 1'b1};
		end else begin
			sq_r_nxt    = sq_rsh;
			sq_root_nxt = {sq_root_q[ROOT_W-2:0], 1'b0};
		end
	end

	assign stat.sqrt_done = sq_busy_q && (sq_c_q == SQC_W'(ROOT_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_c_q    <= '0;
		end else if (cmd.sqrt_start) begin
			sq_busy_q <= 1'b1;
			sq_c_q    <= '0;
		end else if (sq_busy_q) begin
			sq_c_q <= sq_c_q + 1'b1;
			if (stat.sqrt_done) begin
				sq_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sq_x_q    <= rad_init;
			sq_r_q    <= '0;
			sq_root_q <= '0;
		end else if (sq_busy_q) begin
			sq_x_q    <= {sq_x_q[RAD_W-3:0], 2'b00};
			sq_r_q    <= sq_r_nxt;
			sq_root_q <= sq_root_nxt;
			if (stat.sqrt_done) begin
				if (cmd.sqrt_sel) begin
					s2_q <= sq_root_nxt;
				end else begin
					s1_q <= sq_root_nxt;
				end
			end
		end
	end

	// Divider operands. Both quotients round half up by adding half the divisor.
	logic [DVS_W-1:0] dv_den;
	logic [DVD_W-1:0] dv_num, dv_dvd_init;
	logic [DVS_W-1:0] dv_dvs_init;

	always_comb begin
		dv_den = (DVS_W'(cnt_q) << 12) + (DVS_W'(cnt_q) << 10);
		dv_num = ((DVD_W'(s1_q) << 3) + (DVD_W'(s1_q) << 1) + (DVD_W'(s2_q) << 1)
			+ DVD_W'(s2_q)) << FRAC_BITS;
		if (cmd.div_sel) begin
			dv_dvd_init = dv_num + DVD_W'(dv_den >> 1);
			dv_dvs_init = dv_den;
		end else begin
			dv_dvd_init = (DVD_W'(gsum_q) << FRAC_BITS) + DVD_W'(cnt_q >> 1);
			dv_dvs_init = DVS_W'(cnt_q);
		end
	end

	// Restoring divider, one quotient bit per cycle.
	logic [DVD_W-1:0] dv_q_q, dv_q_nxt;
	logic [DVS_W-1:0] dv_s_q;
	logic [DVS_W:0]   dv_r_q, dv_rsh, dv_r_nxt;
	logic [DVC_W-1:0] dv_c_q;
	logic             dv_busy_q;
	logic [BM_W-1:0]  bm_q;
	logic [CV_W-1:0]  cv_q;

	always_comb begin
		dv_rsh = {dv_r_q[DVS_W-1:0], dv_q_q[DVD_W-1]};
		if (dv_rsh >= {1'b0, dv_s_q}) begin
			dv_r_nxt = dv_rsh - {1'b0, dv_s_q};
			dv_q_nxt = {dv_q_q[DVD_W-2:0], 1'b1};
		end else begin
			dv_r_nxt = dv_rsh;
			dv_q_nxt = {dv_q_q[DVD_W-2:0], 1'b0};
		end
	end

	assign stat.div_done = dv_busy_q && (dv_c_q == DVC_W'(DVD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_c_q    <= '0;
		end else if (cmd.div_start) begin
			dv_busy_q <= 1'b1;
			dv_c_q    <= '0;
		end else if (dv_busy_q) begin
			dv_c_q <= dv_c_q + 1'b1;
			if (stat.div_done) begin
				dv_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dv_q_q <= dv_dvd_init;
			dv_s_q <= dv_dvs_init;
			dv_r_q <= '0;
		end else if (dv_busy_q) begin
			dv_q_q <= dv_q_nxt;
			dv_r_q <= dv_r_nxt;
			if (stat.div_done) begin
				if (cmd.div_sel) begin
					cv_q <= (dv_q_nxt > DVD_W'({CV_W{1'b1}})) ? '1 : dv_q_nxt[CV_W-1:0];
				end else begin
					bm_q <= (dv_q_nxt > DVD_W'({BM_W{1'b1}})) ? '1 : dv_q_nxt[BM_W-1:0];
				end
			end
		end
	end

	// Output register; the classifier runs as the word is loaded.
	logic             bright, colorful;
	logic [CLS_W-1:0] cls;
	logic             ovalid_q;

	always_comb begin
		bright   = bm_q > (BM_W'(bthr_q) << FRAC_BITS);
		colorful = cv_q >= (CV_W'(cthr_q) << FRAC_BITS);
		if (bright && !colorful) begin
			cls = CLS_BRIGHT;
		end else if (colorful) begin
			cls = CLS_COLORFUL;
		end else begin
			cls = CLS_OTHER;
		end
	end

	assign stat.out_free = !ovalid_q || out_ready;
	assign out_valid     = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			brightness_mean    <= bm_q;
			colorfulness_value <= cv_q;
			frame_class        <= cls;
		end
	end

endmodule

// ----- design/image_brightness_colorfulness_classifier.sv -----
// Top level of the frame brightness and colorfulness classifier.
//
// Pixels arrive on the in_valid/in_ready channel as red, green, blue and last_pixel, one
// word per cycle while the block is accumulating. A word with last_pixel set closes the
// frame: the block then stops taking pixels and works out the mean, the deviations and the
// colorfulness with one shared serial multiplier (4 products), a digit-serial square root
// (2 roots) and a restoring divider (2 quotients), each operation started and then waited
// on in turn, followed by a load step. The result word goes onto the out channel, and
// in_ready rises again in that same cycle.
// The result word waits in an output register until out_ready; meanwhile the next frame's
// pixels are accepted. If a second frame finishes while that word is still waiting, the
// block holds in_ready low until the output register is free.
// The user must write the thresholds on cfg_we/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce this.
// Reset clears the accumulators and restores the thresholds to 60 and 30.
module image_brightness_colorfulness_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic                          last_pixel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ibcc_pkg::BM_W-1:0]     brightness_mean,
	output logic [ibcc_pkg::CV_W-1:0]     colorfulness_value,
	output logic [ibcc_pkg::CLS_W-1:0]    frame_class,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [ibcc_pkg::CFGD_W-1:0]   cfg_data
);
	import ibcc_pkg::*;

	ibcc_cmd_t  cmd;
	ibcc_stat_t stat;

	ibcc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_pixel (last_pixel),
		.stat       (stat),
		.cmd        (cmd)
	);

	ibcc_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.red                (red),
		.green              (green),
		.blue               (blue),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.cmd                (cmd),
		.stat               (stat),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.brightness_mean    (brightness_mean),
		.colorfulness_value (colorfulness_value),
		.frame_class        (frame_class)
	);

endmodule
